>>> rtl/piecewise_hermite_curve_engine_top_defines.svh
// assertion macros for the curve engine
`ifndef PIECEWISE_HERMITE_CURVE_ENGINE_TOP_DEFINES_SVH
`define PIECEWISE_HERMITE_CURVE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phc check failed");

// next-cycle implication
`define PHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phc check failed");

`endif

>>> rtl/phc_pkg.sv
package phc_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int MAX_POINTS         = 64;
    localparam int CHORDS_PER_SEGMENT = 10;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int K_W   = $clog2(CHORDS_PER_SEGMENT + 1);
    localparam int U_W   = FRAC_BITS + 1;
    localparam int QCNT_W = $clog2(FRAC_BITS + 1);

    localparam logic [30:0] LEN_MAX = '1;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_UNIF = 2'd1;
    localparam logic [1:0] OP_ARC  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [U_W-1:0] chord_tab_t [0:CHORDS_PER_SEGMENT];

    // u for each chord end, k/CHORDS in fixed point, floored
    function automatic chord_tab_t chord_table();
        chord_tab_t tab;
        for (int k = 0; k <= CHORDS_PER_SEGMENT; k++)
        begin
            tab[k] = U_W'((k << FRAC_BITS) / CHORDS_PER_SEGMENT);
        end
        return tab;
    endfunction

    localparam chord_tab_t CHORD_U = chord_table();

endpackage

>>> rtl/phc_isqrt.sv
module phc_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import phc_pkg::*;

    logic [63:0] val_reg, val_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    // one result bit per cycle, two radicand bits consumed
    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[33:0], val_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/phc_div.sv
module phc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [30:0]                   num,
    input  logic [30:0]                   span,
    output logic                          done,
    output logic [phc_pkg::FRAC_BITS-1:0] quot
);
    import phc_pkg::*;

    logic [31:0]           rem_reg, rem_next;
    logic [30:0]           den_reg, den_next;
    logic [FRAC_BITS-1:0]  q_reg, q_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [31:0]           rem_sh;

    // restoring division, num below span so only fraction bits come out
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[30:0], 1'b0};
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = span;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + QCNT_W'(1);
            if (cnt_reg == QCNT_W'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/piecewise_hermite_curve_engine_top.sv
// channel  | handshake            | word
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | op, pos_x, pos_y, in_x, in_y, out_x, out_y,
//          |                      | curve_param
// out      | out_valid / out_stall| point_x, point_y, total_length, points_held,
//          |                      | status
//
// one word at a time; in_stall is high from acceptance until the result
//   is moved to the output register. a full add, first add, empty or unknown op
//   goes straight to the done state; a Hermite evaluation runs on the shared 33x33
//   multiplier, and a uniform evaluation adds the segment select before it; an add
//   runs ten chords, each a Hermite evaluation plus a wait on the bit-serial square root.
// arc evaluation walks the segment start table (one memory read port), then
//   waits on the divider before the Hermite evaluation; a clamp skips both.
// reset clears the sequencer, point count, arc length and output valid only;
//   tables need no clearing since only written entries are read.
// a result sitting in the output register does not block the next input word;
//   the next finished result holds in_stall high while out_stall keeps it full.
module piecewise_hermite_curve_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] curve_param,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [30:0]        total_length,
    output logic [6:0]         points_held,
    output logic [1:0]         status
);
    import phc_pkg::*;

    `include "piecewise_hermite_curve_engine_top_defines.svh"

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ADD_RD   = 5'd1;
    localparam logic [4:0] S_ADD_PREV = 5'd2;
    localparam logic [4:0] S_CH_SETUP = 5'd3;
    localparam logic [4:0] S_H_U2     = 5'd4;
    localparam logic [4:0] S_H_U3     = 5'd5;
    localparam logic [4:0] S_H_COEF   = 5'd6;
    localparam logic [4:0] S_H_RD0    = 5'd7;
    localparam logic [4:0] S_H_RD1    = 5'd8;
    localparam logic [4:0] S_H_RD2    = 5'd9;
    localparam logic [4:0] S_H_MUL    = 5'd10;
    localparam logic [4:0] S_H_ACC    = 5'd11;
    localparam logic [4:0] S_CH_DIFF  = 5'd12;
    localparam logic [4:0] S_CH_SQX   = 5'd13;
    localparam logic [4:0] S_CH_SQY   = 5'd14;
    localparam logic [4:0] S_CH_SQS   = 5'd15;
    localparam logic [4:0] S_CH_SQRT  = 5'd16;
    localparam logic [4:0] S_EV_MUL   = 5'd17;
    localparam logic [4:0] S_EV_SEL   = 5'd18;
    localparam logic [4:0] S_EV_ARC   = 5'd19;
    localparam logic [4:0] S_SR_ADDR  = 5'd20;
    localparam logic [4:0] S_SR_CMP   = 5'd21;
    localparam logic [4:0] S_SR_DIV   = 5'd22;
    localparam logic [4:0] S_RD_PT    = 5'd23;
    localparam logic [4:0] S_RD_PT2   = 5'd24;
    localparam logic [4:0] S_DONE     = 5'd25;

    localparam int H_W = U_W + 3;

    // point tables, written on add, one shared read address
    logic [63:0] positions    [0:MAX_POINTS-1];
    logic [63:0] tangents_in  [0:MAX_POINTS-1];
    logic [63:0] tangents_out [0:MAX_POINTS-1];
    logic [30:0] seg_start    [0:MAX_POINTS-1];

    logic [63:0] pos_rd_reg, tin_rd_reg, tout_rd_reg;
    logic [30:0] ssl_rd_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [30:0]      arc_reg, arc_next;
    logic [1:0]       op_reg, op_next;
    logic signed [31:0] t_reg, t_next;
    logic [1:0]       status_reg, status_next;

    logic [U_W-1:0]   u_reg, u_next;
    logic [U_W-1:0]   u2_reg, u2_next;
    logic signed [H_W-1:0] h_reg [0:3];
    logic signed [H_W-1:0] h_next [0:3];
    logic [IDX_W-1:0] seg_reg, seg_next;
    logic [IDX_W-1:0] pt_reg, pt_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [2:0]       j_reg, j_next;

    logic signed [32:0] p0_reg [0:1];
    logic signed [32:0] t0_reg [0:1];
    logic signed [32:0] p1_reg [0:1];
    logic signed [32:0] t1_reg [0:1];
    logic signed [32:0] p0_next [0:1];
    logic signed [32:0] t0_next [0:1];
    logic signed [32:0] p1_next [0:1];
    logic signed [32:0] t1_next [0:1];

    logic signed [63:0] acc_reg, acc_next, acc_sum;
    logic signed [31:0] res_reg [0:1];
    logic signed [31:0] res_next [0:1];
    logic signed [31:0] prev_reg [0:1];
    logic signed [31:0] prev_next [0:1];
    logic signed [31:0] d_reg [0:1];
    logic signed [31:0] d_next [0:1];
    logic [63:0]        sq_reg, sq_next;
    logic [30:0]        lo_reg, lo_next;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic        div_start, div_done;
    logic [FRAC_BITS-1:0] div_quot;
    logic [30:0] div_num, div_span;

    logic        in_take;
    logic        out_valid_reg;
    logic signed [31:0] point_x_reg, point_y_reg;
    logic [30:0] total_len_reg;
    logic [6:0]  held_reg;
    logic [1:0]  stat_out_reg;
    logic        out_load;

    logic        ssl_we;
    logic [30:0] ssl_wdata;
    logic [IDX_W-1:0] last_idx;
    logic signed [49:0] first_seg;
    logic [U_W-1:0] u3_val;
    logic [32:0] arc_sum;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d > 33'sd2147483647)
            return 32'sh7fffffff;
        else if (d < -33'sd2147483647)
            return 32'sh80000001;
        else
            return d[31:0];
    endfunction

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign first_seg = prod_reg[65:FRAC_BITS];
    assign u3_val   = prod_reg[FRAC_BITS+U_W-1:FRAC_BITS];
    assign acc_sum  = acc_reg + prod_reg[63:0];
    assign arc_sum  = {2'b00, arc_reg} + {1'b0, sq_root};

    // read address per state
    always_comb
    begin
        unique case (state_reg)
            S_ADD_RD:  rd_addr = last_idx;
            S_H_RD0:   rd_addr = seg_reg;
            S_H_RD1:   rd_addr = seg_reg + IDX_W'(1);
            S_SR_ADDR: rd_addr = seg_reg + IDX_W'(1);
            default:   rd_addr = pt_reg;
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_H_U2:
            begin
                mul_a = $signed(33'(u_reg));
                mul_b = $signed(33'(u_reg));
            end
            S_H_U3:
            begin
                mul_a = $signed(33'(prod_reg[FRAC_BITS+U_W-1:FRAC_BITS]));
                mul_b = $signed(33'(u_reg));
            end
            S_H_MUL:
            begin
                mul_a = 33'(h_reg[j_reg[1:0]]);
                case (j_reg[1:0])
                    2'd0:    mul_b = p0_reg[j_reg[2]];
                    2'd1:    mul_b = t0_reg[j_reg[2]];
                    2'd2:    mul_b = p1_reg[j_reg[2]];
                    default: mul_b = t1_reg[j_reg[2]];
                endcase
            end
            S_CH_SQX:
            begin
                mul_a = 33'(d_reg[0]);
                mul_b = 33'(d_reg[0]);
            end
            S_CH_SQY:
            begin
                mul_a = 33'(d_reg[1]);
                mul_b = 33'(d_reg[1]);
            end
            S_EV_MUL:
            begin
                mul_a = 33'(t_reg);
                mul_b = $signed(33'(count_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        arc_next    = arc_reg;
        op_next     = op_reg;
        t_next      = t_reg;
        status_next = status_reg;
        u_next      = u_reg;
        u2_next     = u2_reg;
        h_next      = h_reg;
        seg_next    = seg_reg;
        pt_next     = pt_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        p0_next     = p0_reg;
        t0_next     = t0_reg;
        p1_next     = p1_reg;
        t1_next     = t1_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        prev_next   = prev_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        lo_next     = lo_reg;
        sq_start    = 1'b0;
        div_start   = 1'b0;
        ssl_we      = 1'b0;
        ssl_wdata   = arc_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next     = op;
                    t_next      = curve_param;
                    status_next = ST_OK;
                    res_next[0] = '0;
                    res_next[1] = '0;
                    k_next      = K_W'(1);
                    state_next  = S_DONE;
                    if (op == OP_ADD)
                    begin
                        if (count_reg >= CNT_W'(MAX_POINTS))
                            status_next = ST_FULL;
                        else if (count_reg == '0)
                        begin
                            ssl_we     = 1'b1;
                            ssl_wdata  = '0;
                            count_next = CNT_W'(1);
                        end
                        else
                            state_next = S_ADD_RD;
                    end
                    else if (op == OP_UNIF || op == OP_ARC)
                    begin
                        if (count_reg == '0)
                            status_next = ST_EMPTY;
                        else if (op == OP_UNIF)
                            state_next = S_EV_MUL;
                        else
                            state_next = S_EV_ARC;
                    end
                end
            end
            S_ADD_RD:
                state_next = S_ADD_PREV;
            S_ADD_PREV:
            begin
                prev_next[0] = pos_rd_reg[31:0];
                prev_next[1] = pos_rd_reg[63:32];
                state_next   = S_CH_SETUP;
            end
            S_CH_SETUP:
            begin
                // new point not yet counted, so its segment starts at the last one
                u_next     = CHORD_U[k_reg];
                seg_next   = last_idx;
                state_next = S_H_U2;
            end
            S_H_U2:
                state_next = S_H_U3;
            S_H_U3:
            begin
                u2_next    = prod_reg[FRAC_BITS+U_W-1:FRAC_BITS];
                state_next = S_H_COEF;
            end
            S_H_COEF:
            begin
                // basis weights from u, u^2, u^3
                h_next[0] = H_W'(2 * $signed(H_W'(u3_val)) - 3 * $signed(H_W'(u2_reg))
                                 + $signed(H_W'(1 << FRAC_BITS)));
                h_next[1] = H_W'($signed(H_W'(u3_val)) - 2 * $signed(H_W'(u2_reg))
                                 + $signed(H_W'(u_reg)));
                h_next[2] = H_W'(3 * $signed(H_W'(u2_reg)) - 2 * $signed(H_W'(u3_val)));
                h_next[3] = $signed(H_W'(u3_val)) - $signed(H_W'(u2_reg));
                state_next = S_H_RD0;
            end
            S_H_RD0:
                state_next = S_H_RD1;
            S_H_RD1:
            begin
                p0_next[0] = 33'($signed(pos_rd_reg[31:0]));
                p0_next[1] = 33'($signed(pos_rd_reg[63:32]));
                t0_next[0] = 33'($signed(tout_rd_reg[31:0]));
                t0_next[1] = 33'($signed(tout_rd_reg[63:32]));
                state_next = S_H_RD2;
            end
            S_H_RD2:
            begin
                p1_next[0] = 33'($signed(pos_rd_reg[31:0]));
                p1_next[1] = 33'($signed(pos_rd_reg[63:32]));
                // incoming tangent enters negated
                t1_next[0] = -33'($signed(tin_rd_reg[31:0]));
                t1_next[1] = -33'($signed(tin_rd_reg[63:32]));
                j_next     = '0;
                acc_next   = '0;
                state_next = S_H_MUL;
            end
            S_H_MUL:
                state_next = S_H_ACC;
            S_H_ACC:
            begin
                if (j_reg[1:0] == 2'd3)
                begin
                    res_next[j_reg[2]] = sat32(acc_sum >>> FRAC_BITS);
                    acc_next = '0;
                end
                else
                    acc_next = acc_sum;
                j_next = j_reg + 3'd1;
                if (j_reg == 3'd7)
                    state_next = (op_reg == OP_ADD) ? S_CH_DIFF : S_DONE;
                else
                    state_next = S_H_MUL;
            end
            S_CH_DIFF:
            begin
                d_next[0]    = clamp_mag(res_reg[0], prev_reg[0]);
                d_next[1]    = clamp_mag(res_reg[1], prev_reg[1]);
                prev_next[0] = res_reg[0];
                prev_next[1] = res_reg[1];
                state_next   = S_CH_SQX;
            end
            S_CH_SQX:
                state_next = S_CH_SQY;
            S_CH_SQY:
            begin
                sq_next    = prod_reg[63:0];
                state_next = S_CH_SQS;
            end
            S_CH_SQS:
            begin
                sq_start   = 1'b1;
                state_next = S_CH_SQRT;
            end
            S_CH_SQRT:
            begin
                if (sq_done)
                begin
                    arc_next = (arc_sum > 33'(LEN_MAX)) ? LEN_MAX : arc_sum[30:0];
                    if (k_reg == K_W'(CHORDS_PER_SEGMENT))
                    begin
                        ssl_we      = 1'b1;
                        ssl_wdata   = arc_next;
                        count_next  = count_reg + CNT_W'(1);
                        res_next[0] = '0;
                        res_next[1] = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        state_next = S_CH_SETUP;
                    end
                end
            end
            S_EV_MUL:
                state_next = S_EV_SEL;
            S_EV_SEL:
            begin
                if (first_seg >= $signed(50'(last_idx)))
                begin
                    pt_next    = last_idx;
                    state_next = S_RD_PT;
                end
                else if (!first_seg[49])
                begin
                    seg_next   = IDX_W'(first_seg);
                    u_next     = U_W'(prod_reg[FRAC_BITS-1:0]);
                    state_next = S_H_U2;
                end
                else
                begin
                    pt_next    = '0;
                    state_next = S_RD_PT;
                end
            end
            S_EV_ARC:
            begin
                if (t_reg > 0 && t_reg >= $signed({1'b0, arc_reg}))
                begin
                    pt_next    = last_idx;
                    state_next = S_RD_PT;
                end
                else if (t_reg > 0)
                begin
                    seg_next   = '0;
                    lo_next    = '0;
                    state_next = S_SR_ADDR;
                end
                else
                begin
                    pt_next    = '0;
                    state_next = S_RD_PT;
                end
            end
            S_SR_ADDR:
                state_next = S_SR_CMP;
            S_SR_CMP:
            begin
                if (t_reg < $signed({1'b0, ssl_rd_reg}))
                begin
                    div_start  = 1'b1;
                    state_next = S_SR_DIV;
                end
                else
                begin
                    lo_next    = ssl_rd_reg;
                    seg_next   = seg_reg + IDX_W'(1);
                    state_next = S_SR_ADDR;
                end
            end
            S_SR_DIV:
            begin
                if (div_done)
                begin
                    u_next     = U_W'(div_quot);
                    state_next = S_H_U2;
                end
            end
            S_RD_PT:
                state_next = S_RD_PT2;
            S_RD_PT2:
            begin
                res_next[0] = pos_rd_reg[31:0];
                res_next[1] = pos_rd_reg[63:32];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign div_num  = t_reg[30:0] - lo_reg;
    assign div_span = ssl_rd_reg - lo_reg;

    phc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_reg + prod_reg[63:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    phc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .span  (div_span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // tables
    always_ff @(posedge clk)
    begin
        if (in_take && op == OP_ADD && count_reg < CNT_W'(MAX_POINTS))
        begin
            positions[count_reg[IDX_W-1:0]]    <= {pos_y, pos_x};
            tangents_in[count_reg[IDX_W-1:0]]  <= {in_y, in_x};
            tangents_out[count_reg[IDX_W-1:0]] <= {out_y, out_x};
        end
        if (ssl_we)
            seg_start[count_reg[IDX_W-1:0]] <= ssl_wdata;
        pos_rd_reg  <= positions[rd_addr];
        tin_rd_reg  <= tangents_in[rd_addr];
        tout_rd_reg <= tangents_out[rd_addr];
        ssl_rd_reg  <= seg_start[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            arc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            arc_reg   <= arc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        t_reg      <= t_next;
        status_reg <= status_next;
        u_reg      <= u_next;
        u2_reg     <= u2_next;
        h_reg      <= h_next;
        seg_reg    <= seg_next;
        pt_reg     <= pt_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        p0_reg     <= p0_next;
        t0_reg     <= t0_next;
        p1_reg     <= p1_next;
        t1_reg     <= t1_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        prev_reg   <= prev_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        lo_reg     <= lo_next;
        if (out_load)
        begin
            point_x_reg   <= res_reg[0];
            point_y_reg   <= res_reg[1];
            total_len_reg <= arc_reg;
            held_reg      <= 7'(count_reg);
            stat_out_reg  <= status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign total_length = total_len_reg;
    assign points_held  = held_reg;
    assign status       = stat_out_reg;

    // checks
    `PHC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `PHC_ASSERT_NOW(a_full_status, out_valid && status == ST_FULL, points_held == 7'(MAX_POINTS))
    `PHC_ASSERT_NEXT(a_arc_monotone, 1'b1, arc_reg >= $past(arc_reg))
    `PHC_ASSERT_NOW(a_root_in_chord, sq_done, state_reg == S_CH_SQRT)

endmodule
